// ===== hdl/prds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pollard rho divisor search package
// Shared widths, codes, transaction types and a modular add helper.
// ----------------------------------------------------------------------------
package prds_pkg;

    localparam int MOD_W   = 32;
    localparam int ROUND_W = 20;
    localparam int CNT_W   = $clog2(MOD_W);
    localparam int SHIFT_W = $clog2(MOD_W) + 1;

    localparam logic [ROUND_W-1:0] ROUNDS_RESET = ROUND_W'(65535);

    localparam logic [1:0] STATUS_PROPER  = 2'd0;
    localparam logic [1:0] STATUS_TRIVIAL = 2'd1;
    localparam logic [1:0] STATUS_CAP     = 2'd2;

    typedef struct packed {
        logic [31:0] modulus;
        logic [31:0] start_value;
        logic [31:0] increment;
    } in_item_t;

    typedef struct packed {
        logic [31:0] divisor;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [MOD_W-1:0] a;
        logic [MOD_W-1:0] b;
        logic [MOD_W-1:0] n;
    } mul_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_X,
        ST_RED_C,
        ST_CHECK,
        ST_MUL,
        ST_ADD,
        ST_GCD,
        ST_DONE
    } state_t;

    // Sum of two residues reduced once; both operands must be below n.
    function automatic logic [MOD_W-1:0] add_mod(input logic [MOD_W-1:0] a,
                                                 input logic [MOD_W-1:0] b,
                                                 input logic [MOD_W-1:0] n);
        logic [MOD_W:0] sum;
        logic [MOD_W:0] red;
        sum = {1'b0, a} + {1'b0, b};
        red = sum - {1'b0, n};
        if (sum >= {1'b0, n})
            return red[MOD_W-1:0];
        return sum[MOD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/prds_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes a*b mod n by shift and add, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module prds_mulmod
    import prds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mul_req_t         req,
    output logic                  done,
    output logic [MOD_W-1:0]      result
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_W-1:0] acc_reg, acc_next;
    logic [MOD_W-1:0] a_reg, a_next;
    logic [MOD_W-1:0] b_reg, b_next;
    logic [MOD_W-1:0] n_reg, n_next;
    logic [MOD_W-1:0] dbl;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        n_next    = n_reg;
        dbl       = add_mod(acc_reg, acc_reg, n_reg);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MOD_W - 1);
            acc_next  = '0;
            a_next    = req.a;
            b_next    = req.b;
            n_next    = req.n;
        end
        else if (busy_reg)
        begin
            acc_next = add_mod(dbl, b_reg[MOD_W-1] ? a_reg : '0, n_reg);
            b_next   = {b_reg[MOD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        n_reg   <= n_next;
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

// ===== hdl/prds_gcd.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Binary gcd unit
// Computes gcd(a, b) with one shift or subtract step per cycle.
// ----------------------------------------------------------------------------
module prds_gcd
    import prds_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MOD_W-1:0] a,
    input  wire logic [MOD_W-1:0] b,
    output logic                  done,
    output logic [MOD_W-1:0]      result
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [MOD_W-1:0]   a_reg, a_next;
    logic [MOD_W-1:0]   b_reg, b_next;
    logic [SHIFT_W-1:0] k_reg, k_next;
    logic [MOD_W-1:0]   res_reg, res_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        k_next    = k_reg;
        res_next  = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            a_next    = a;
            b_next    = b;
            k_next    = '0;
        end
        else if (busy_reg)
        begin
            priority if (a_reg == '0)
            begin
                res_next  = b_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (b_reg == '0)
            begin
                res_next  = a_reg << k_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else if (!a_reg[0] && !b_reg[0])
            begin
                a_next = a_reg >> 1;
                b_next = b_reg >> 1;
                k_next = k_reg + 1'b1;
            end
            else if (!a_reg[0])
                a_next = a_reg >> 1;
            else if (!b_reg[0])
                b_next = b_reg >> 1;
            else if (a_reg >= b_reg)
                a_next = a_reg - b_reg;
            else
                b_next = b_reg - a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ===== hdl/pollard_rho_divisor_search.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pollard rho divisor search
// Runs Pollard's rho with Floyd cycle finding and returns the first divisor.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. Each modular squaring runs in the
// bit-serial multiplier, as do the reductions of the start value and the
// increment, and each gcd runs in the binary gcd unit. The number of rounds
// run is bounded by max_rounds. A finished result waits in an output
// register, so the next transaction is taken while it is still pending.
module pollard_rho_divisor_search
    import prds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    input  wire logic               cfg_wr_en,
    input  wire logic [ROUND_W-1:0] cfg_wr_data
);

    state_t             state_reg, state_next;
    logic [MOD_W-1:0]   n_reg, x_reg, y_reg, c_reg, d_reg, inc_reg;
    logic [ROUND_W-1:0] rounds_reg, max_rounds_reg;
    logic [1:0]         step_reg, status_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               mul_start, mul_done, gcd_start, gcd_done;
    mul_req_t           mul_req;
    logic [MOD_W-1:0]   mul_result, gcd_result, walk, diff;
    logic               accept, finish, small_n;

    assign accept  = in_valid && (state_reg == ST_IDLE);
    assign small_n = (in_data.modulus < 32'd2);
    assign walk    = add_mod(mul_result, c_reg, n_reg);
    assign diff    = (x_reg >= walk) ? (x_reg - walk) : (walk - x_reg);
    assign finish  = (rounds_reg >= max_rounds_reg) || (d_reg != MOD_W'(1));

    prds_mulmod u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_result)
    );

    prds_gcd u_gcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (gcd_start),
        .a      (diff),
        .b      (n_reg),
        .done   (gcd_done),
        .result (gcd_result)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = small_n ? ST_DONE : ST_RED_X;
            ST_RED_X: if (mul_done) state_next = ST_RED_C;
            ST_RED_C: if (mul_done) state_next = ST_CHECK;
            ST_CHECK: state_next = finish ? ST_DONE : ST_MUL;
            ST_MUL:   if (mul_done) state_next = ST_ADD;
            ST_ADD:   state_next = (step_reg == 2'd2) ? ST_GCD : ST_MUL;
            ST_GCD:   if (gcd_done) state_next = ST_CHECK;
            ST_DONE:  if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mul_start = 1'b0;
        gcd_start = 1'b0;
        mul_req.a = MOD_W'(1);
        mul_req.b = in_data.start_value;
        mul_req.n = in_data.modulus;
        unique case (state_reg)
            ST_IDLE:  mul_start = accept && !small_n;
            ST_RED_X:
            begin
                mul_start = mul_done;
                mul_req.b = inc_reg;
                mul_req.n = n_reg;
            end
            ST_CHECK:
            begin
                mul_start = !finish;
                mul_req.a = x_reg;
                mul_req.b = x_reg;
                mul_req.n = n_reg;
            end
            ST_ADD:
            begin
                mul_start = (step_reg != 2'd2);
                mul_req.a = (step_reg == 2'd0) ? y_reg : walk;
                mul_req.b = (step_reg == 2'd0) ? y_reg : walk;
                mul_req.n = n_reg;
                gcd_start = (step_reg == 2'd2);
            end
            default:
            begin
                mul_start = 1'b0;
                gcd_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            max_rounds_reg <= ROUNDS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                max_rounds_reg <= cfg_wr_data;
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                n_reg      <= in_data.modulus;
                inc_reg    <= in_data.increment;
                d_reg      <= MOD_W'(1);
                rounds_reg <= '0;
                status_reg <= STATUS_TRIVIAL;
            end
            ST_RED_X: if (mul_done) x_reg <= mul_result;
            ST_RED_C:
            begin
                if (mul_done)
                begin
                    c_reg <= mul_result;
                    y_reg <= x_reg;
                end
            end
            ST_CHECK:
            begin
                step_reg <= 2'd0;
                if (d_reg == MOD_W'(1))
                    status_reg <= STATUS_CAP;
                else if (d_reg == n_reg)
                    status_reg <= STATUS_TRIVIAL;
                else
                    status_reg <= STATUS_PROPER;
            end
            ST_ADD:
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd0)
                    x_reg <= walk;
                else
                    y_reg <= walk;
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    d_reg      <= gcd_result;
                    rounds_reg <= rounds_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_reg.divisor <= d_reg;
                    out_data_reg.status  <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== hdl/prds_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Pollard rho divisor search checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module prds_checker
    import prds_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_ready,
    input wire out_item_t out_data
);

    // A pending result transaction holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("undefined status code");

    a_cap_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_CAP |-> out_data.divisor == 32'd1)
        else $error("cap status with divisor other than one");

    a_proper_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_PROPER |-> out_data.divisor > 32'd1)
        else $error("proper factor status with trivial divisor");

endmodule

bind pollard_rho_divisor_search prds_checker u_prds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
